// ===== src/cle_pkg.sv =====
// Shared types, constants and helper functions for the canonical line editor.
// No dependencies; used by the line editor and its testbench.
package cle_pkg;

  // Line store geometry (depth must be a power of two).
  localparam int BUF_DEPTH = 4096;
  localparam int AW = $clog2(BUF_DEPTH);
  localparam int PW = AW + 1;
  localparam int CW = (PW > 7) ? PW : 7;

  // Result kinds.
  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // Status codes.
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_NOLINE = 3'd2;
  localparam logic [2:0] ST_INTR   = 3'd3;
  localparam logic [2:0] ST_EOF    = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] REG_NEWLINE = 2'd0;
  localparam logic [1:0] REG_ERASE   = 2'd1;
  localparam logic [1:0] REG_INTR    = 2'd2;
  localparam logic [1:0] REG_EOF     = 2'd3;

  // Command codes.
  localparam logic CMD_RX   = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Special bytes.
  localparam logic [7:0] CARET     = 8'h5E;
  localparam logic [7:0] BACKSPACE = 8'h08;
  localparam logic [7:0] SPACE     = 8'h20;
  localparam logic [7:0] LINE_FEED = 8'h0A;
  localparam logic [7:0] CTRL_FLIP = 8'h40;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE, S_RX, S_ER_RD, S_ER_CHK, S_ECHO, S_SC_ADDR, S_SC_CHK,
    S_DECIDE, S_EM_ADDR, S_EM_DATA, S_FIN
  } state_e;

  // A control byte echoes in caret notation.
  function automatic logic is_ctrl(input logic [7:0] c);
    return (c < 8'h20) || (c == 8'h7F);
  endfunction

endpackage

// ===== src/cle_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/canonical_line_editor.sv =====
// A receive issues up to six echo results and then the end marker, and an erase first
// reads the erased byte back from the store; a read scans the store byte by byte for a
// line end, delivers its bytes and then the end marker, and gives only the end marker
// when no line is ready.
// Throughput: one transaction at a time; busy is high until the end marker is issued,
// set by the single line-store read port that the sequencer walks byte by byte.
// Reset clears pointers and the sequencer and loads the default configuration; the store needs no clearing.
// Results are strobed for one cycle each; the receiver cannot stall.
module canonical_line_editor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       command_i,
  input  logic [7:0] rx_byte_i,
  input  logic [5:0] read_limit_i,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output logic       result_valid_o,
  output logic [1:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic [2:0] status_o,
  output logic [6:0] consumed_o,
  output logic       last_o
);

  localparam int AW = cle_pkg::AW;
  localparam int PW = cle_pkg::PW;
  localparam int CW = cle_pkg::CW;

  cle_pkg::state_e state_q, state_d;

  logic [7:0] nl_q, er_q, in_q, eo_q;
  logic [PW-1:0] wp_q, wp_d, rp_q, rp_d, cp_q, cp_d;
  logic       cmd_q, cmd_d;
  logic [7:0] byte_q, byte_d;
  logic [5:0] limit_q, limit_d;
  logic [2:0] st_q, st_d;
  logic [7:0] echo_q [6];
  logic [7:0] echo_d [6];
  logic [2:0] echo_n_q, echo_n_d, echo_i_q, echo_i_d;
  logic [6:0] idx_q, idx_d, window_q, window_d;
  logic       found_q, found_d;
  logic [6:0] e_q, e_d;
  logic [7:0] fbyte_q, fbyte_d;
  logic [6:0] deliver_q, deliver_d, consume_q, consume_d;
  logic       full;
  logic [CW-1:0] avail_c, lim1_c;
  logic       eof_c;
  logic [6:0] e1_c, dl_c;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [8:0]    ram_wdata, ram_rdata;

  logic       vld_d, vld_q, last_d, last_q;
  logic [1:0] kind_d, kind_q;
  logic [7:0] ob_d, ob_q;
  logic [2:0] os_d, os_q;
  logic [6:0] cons_d, cons_q;

  // Line store: byte in the low bits, line-end flag on top.
  cle_ram #(.WIDTH(9), .DEPTH(cle_pkg::BUF_DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy = (state_q != cle_pkg::S_IDLE);
  assign full = ((wp_q - rp_q) >= PW'(cle_pkg::BUF_DEPTH - 1));
  assign avail_c = CW'(cp_q - rp_q);
  assign lim1_c = CW'({1'b0, limit_q} + 7'd1);

  // Read decision terms from the scan result.
  assign eof_c = found_q && (fbyte_q == 8'h00);
  assign e1_c = e_q + 7'd1;
  always_comb begin
    if (found_q) begin
      dl_c = (e1_c > {1'b0, limit_q}) ? {1'b0, limit_q} : e1_c;
    end else begin
      dl_c = (window_q > {1'b0, limit_q}) ? {1'b0, limit_q} : window_q;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      cle_pkg::S_IDLE: begin
        if (start) state_d = cle_pkg::S_RX;
      end
      cle_pkg::S_RX: begin
        if (cmd_q == cle_pkg::CMD_READ) begin
          state_d = (avail_c == '0) ? cle_pkg::S_FIN : cle_pkg::S_SC_ADDR;
        end else if (full) begin
          state_d = cle_pkg::S_FIN;
        end else if (byte_q != nl_q && byte_q == er_q) begin
          state_d = (wp_q != cp_q) ? cle_pkg::S_ER_RD : cle_pkg::S_FIN;
        end else if (byte_q != nl_q && byte_q != in_q && byte_q == eo_q) begin
          state_d = cle_pkg::S_FIN;
        end else begin
          state_d = cle_pkg::S_ECHO;
        end
      end
      cle_pkg::S_ER_RD:  state_d = cle_pkg::S_ER_CHK;
      cle_pkg::S_ER_CHK: state_d = cle_pkg::S_ECHO;
      cle_pkg::S_ECHO: begin
        if (echo_i_q + 3'd1 >= echo_n_q) state_d = cle_pkg::S_FIN;
      end
      cle_pkg::S_SC_ADDR: begin
        state_d = (idx_q == window_q) ? cle_pkg::S_DECIDE : cle_pkg::S_SC_CHK;
      end
      cle_pkg::S_SC_CHK: begin
        state_d = ram_rdata[8] ? cle_pkg::S_DECIDE : cle_pkg::S_SC_ADDR;
      end
      cle_pkg::S_DECIDE: state_d = cle_pkg::S_EM_ADDR;
      cle_pkg::S_EM_ADDR: begin
        state_d = (idx_q == deliver_q) ? cle_pkg::S_FIN : cle_pkg::S_EM_DATA;
      end
      cle_pkg::S_EM_DATA: state_d = cle_pkg::S_EM_ADDR;
      cle_pkg::S_FIN:     state_d = cle_pkg::S_IDLE;
      default:            state_d = cle_pkg::S_IDLE;
    endcase
  end

  // Datapath, store access and result register logic.
  always_comb begin
    wp_d = wp_q; rp_d = rp_q; cp_d = cp_q;
    cmd_d = cmd_q; byte_d = byte_q; limit_d = limit_q; st_d = st_q;
    echo_d = echo_q; echo_n_d = echo_n_q; echo_i_d = echo_i_q;
    idx_d = idx_q; window_d = window_q; found_d = found_q; e_d = e_q;
    fbyte_d = fbyte_q; deliver_d = deliver_q; consume_d = consume_q;
    ram_we = 1'b0; ram_waddr = wp_q[AW-1:0]; ram_wdata = '0;
    ram_raddr = rp_q[AW-1:0];
    vld_d = 1'b0; kind_d = cle_pkg::KIND_END; ob_d = '0; os_d = st_q;
    cons_d = '0; last_d = 1'b0;
    case (state_q)
      cle_pkg::S_IDLE: begin
        if (start) begin
          cmd_d = command_i; byte_d = rx_byte_i; limit_d = read_limit_i;
          st_d = cle_pkg::ST_OK; echo_n_d = '0; echo_i_d = '0;
          idx_d = '0; found_d = 1'b0; e_d = '0; consume_d = '0;
        end
      end
      cle_pkg::S_RX: begin
        if (cmd_q == cle_pkg::CMD_READ) begin
          if (avail_c == '0) begin
            st_d = cle_pkg::ST_NOLINE;
          end else begin
            window_d = (avail_c >= lim1_c) ? lim1_c[6:0] : avail_c[6:0];
          end
        end else if (full) begin
          st_d = cle_pkg::ST_FULL;
        end else if (byte_q == nl_q) begin
          echo_d[0] = cle_pkg::LINE_FEED; echo_n_d = 3'd1;
          ram_we = 1'b1; ram_wdata = {1'b1, cle_pkg::LINE_FEED};
          wp_d = wp_q + PW'(1); cp_d = wp_q + PW'(1);
        end else if (byte_q == er_q) begin
          if (wp_q != cp_q) wp_d = wp_q - PW'(1);
        end else if (byte_q == in_q) begin
          echo_d[0] = cle_pkg::CARET;
          echo_d[1] = byte_q ^ cle_pkg::CTRL_FLIP;
          echo_d[2] = cle_pkg::LINE_FEED; echo_n_d = 3'd3;
          ram_we = 1'b1; ram_wdata = {1'b1, cle_pkg::LINE_FEED};
          rp_d = wp_q; wp_d = wp_q + PW'(1); cp_d = wp_q + PW'(1);
          st_d = cle_pkg::ST_INTR;
        end else if (byte_q == eo_q) begin
          ram_we = 1'b1; ram_wdata = {1'b1, 8'h00};
          wp_d = wp_q + PW'(1); cp_d = wp_q + PW'(1);
        end else begin
          if (cle_pkg::is_ctrl(byte_q)) begin
            echo_d[0] = cle_pkg::CARET;
            echo_d[1] = byte_q ^ cle_pkg::CTRL_FLIP; echo_n_d = 3'd2;
          end else begin
            echo_d[0] = byte_q; echo_n_d = 3'd1;
          end
          ram_we = 1'b1; ram_wdata = {1'b0, byte_q};
          wp_d = wp_q + PW'(1);
        end
      end
      cle_pkg::S_ER_RD: begin
        ram_raddr = wp_q[AW-1:0];
      end
      cle_pkg::S_ER_CHK: begin
        for (int i = 0; i < 6; i++) begin
          echo_d[i] = ((i % 3) == 1) ? cle_pkg::SPACE : cle_pkg::BACKSPACE;
        end
        echo_n_d = cle_pkg::is_ctrl(ram_rdata[7:0]) ? 3'd6 : 3'd3;
      end
      cle_pkg::S_ECHO: begin
        vld_d = 1'b1; kind_d = cle_pkg::KIND_ECHO; ob_d = echo_q[echo_i_q];
        echo_i_d = echo_i_q + 3'd1;
      end
      cle_pkg::S_SC_ADDR: begin
        ram_raddr = AW'(rp_q + PW'(idx_q));
      end
      cle_pkg::S_SC_CHK: begin
        if (ram_rdata[8]) begin
          found_d = 1'b1; e_d = idx_q; fbyte_d = ram_rdata[7:0];
        end else begin
          idx_d = idx_q + 7'd1;
        end
      end
      cle_pkg::S_DECIDE: begin
        // Release the line-end flag only when its terminator is consumed.
        deliver_d = eof_c ? e_q : dl_c;
        consume_d = eof_c ? e1_c : dl_c;
        if (eof_c) st_d = cle_pkg::ST_EOF;
        ram_waddr = AW'(rp_q + PW'(e_q));
        ram_wdata = {1'b0, fbyte_q};
        ram_we = found_q && (eof_c || (e_q < {1'b0, limit_q}));
        idx_d = '0;
      end
      cle_pkg::S_EM_ADDR: begin
        ram_raddr = AW'(rp_q + PW'(idx_q));
      end
      cle_pkg::S_EM_DATA: begin
        vld_d = 1'b1; kind_d = cle_pkg::KIND_DATA; ob_d = ram_rdata[7:0];
        idx_d = idx_q + 7'd1;
      end
      cle_pkg::S_FIN: begin
        vld_d = 1'b1; kind_d = cle_pkg::KIND_END; last_d = 1'b1;
        cons_d = consume_q;
        rp_d = rp_q + PW'(consume_q);
      end
      default: begin
        vld_d = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cle_pkg::S_IDLE;
      wp_q <= '0; rp_q <= '0; cp_q <= '0;
      nl_q <= 8'd10; er_q <= 8'd127; in_q <= 8'd3; eo_q <= 8'd4;
      vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q <= wp_d; rp_q <= rp_d; cp_q <= cp_d;
      vld_q <= vld_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          cle_pkg::REG_NEWLINE: nl_q <= cfg_data_i;
          cle_pkg::REG_ERASE:   er_q <= cfg_data_i;
          cle_pkg::REG_INTR:    in_q <= cfg_data_i;
          cle_pkg::REG_EOF:     eo_q <= cfg_data_i;
          default:              nl_q <= nl_q;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; byte_q <= byte_d; limit_q <= limit_d; st_q <= st_d;
    echo_q <= echo_d; echo_n_q <= echo_n_d; echo_i_q <= echo_i_d;
    idx_q <= idx_d; window_q <= window_d; found_q <= found_d; e_q <= e_d;
    fbyte_q <= fbyte_d; deliver_q <= deliver_d; consume_q <= consume_d;
    kind_q <= kind_d; ob_q <= ob_d; os_q <= os_d; cons_q <= cons_d;
    last_q <= last_d;
  end

  assign result_valid_o = vld_q;
  assign kind_o = kind_q;
  assign out_byte_o = ob_q;
  assign status_o = os_q;
  assign consumed_o = cons_q;
  assign last_o = last_q;

`ifndef NO_ASSERTIONS
  a_unread_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wp_q - rp_q) <= PW'(cle_pkg::BUF_DEPTH - 1))
    else $error("unread span exceeds store");
  a_commit_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cp_q - rp_q) <= (wp_q - rp_q))
    else $error("committed pointer outside unread span");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");
  a_fin_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cle_pkg::S_FIN) |=> (result_valid_o && last_o))
    else $error("end marker missing");
`endif

endmodule

// ===== tb/tb_canonical_line_editor.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the canonical line editor: receive and read
// transactions are checked against a scoreboard that predicts every result.
// Depends on cle_pkg and canonical_line_editor only.

import cle_pkg::*;

typedef struct packed {
  logic [1:0] kind;
  logic [7:0] data;
  logic [2:0] status;
  logic [6:0] consumed;
  logic       last;
} editor_result_t;

// Scoreboard: mirrors the ring buffer and queues the expected results.
class line_editor_scoreboard;
  logic [7:0]     store_q [BUF_DEPTH];
  logic           flag_q  [BUF_DEPTH];
  logic [12:0]    wr_ptr, rd_ptr, cm_ptr;
  logic [7:0]     regs [4];
  editor_result_t pending [$];
  int             errors;
  int             results_seen;

  function new();
    wr_ptr = '0;
    rd_ptr = '0;
    cm_ptr = '0;
    regs[REG_NEWLINE] = 8'd10;
    regs[REG_ERASE]   = 8'd127;
    regs[REG_INTR]    = 8'd3;
    regs[REG_EOF]     = 8'd4;
    errors = 0;
    results_seen = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [7:0] v);
    regs[idx] = v;
  endfunction

  function void push(logic [1:0] k, logic [7:0] b, logic [2:0] st, logic [6:0] cons,
                     logic fin);
    editor_result_t r;
    r.kind = k;
    r.data = b;
    r.status = st;
    r.consumed = cons;
    r.last = fin;
    pending.push_back(r);
  endfunction

  function void put_byte(logic [7:0] b, logic flag);
    store_q[wr_ptr[AW-1:0]] = b;
    flag_q[wr_ptr[AW-1:0]]  = flag;
    wr_ptr = wr_ptr + 13'd1;
  endfunction

  // Receive: store, edit or terminate, and queue the echo bytes.
  function void receive_byte(logic [7:0] c);
    logic [7:0] echo [6];
    logic [7:0] gone;
    logic [2:0] st;
    int n;
    n = 0;
    st = ST_OK;
    if (13'(wr_ptr - rd_ptr) >= 13'(BUF_DEPTH - 1)) begin
      push(KIND_END, 8'h00, ST_FULL, 7'd0, 1'b1);
      return;
    end
    if (c == regs[REG_NEWLINE]) begin
      echo[n++] = LINE_FEED;
      put_byte(LINE_FEED, 1'b1);
      cm_ptr = wr_ptr;
    end else if (c == regs[REG_ERASE]) begin
      if (wr_ptr != cm_ptr) begin
        wr_ptr = wr_ptr - 13'd1;
        gone = store_q[wr_ptr[AW-1:0]];
        if (gone < 8'h20 || gone == 8'h7F) begin
          echo[n++] = BACKSPACE;
          echo[n++] = SPACE;
          echo[n++] = BACKSPACE;
        end
        echo[n++] = BACKSPACE;
        echo[n++] = SPACE;
        echo[n++] = BACKSPACE;
      end
    end else if (c == regs[REG_INTR]) begin
      echo[n++] = CARET;
      echo[n++] = c ^ CTRL_FLIP;
      echo[n++] = LINE_FEED;
      rd_ptr = wr_ptr;
      put_byte(LINE_FEED, 1'b1);
      cm_ptr = wr_ptr;
      st = ST_INTR;
    end else if (c == regs[REG_EOF]) begin
      put_byte(8'h00, 1'b1);
      cm_ptr = wr_ptr;
    end else begin
      if (c < 8'h20 || c == 8'h7F) begin
        echo[n++] = CARET;
        echo[n++] = c ^ CTRL_FLIP;
      end else begin
        echo[n++] = c;
      end
      put_byte(c, 1'b0);
    end
    for (int i = 0; i < n; i++) push(KIND_ECHO, echo[i], st, 7'd0, 1'b0);
    push(KIND_END, 8'h00, st, 7'd0, 1'b1);
  endfunction

  // Read: scan for the first line end and deliver up to the limit.
  function void read_line(logic [5:0] lim);
    int avail, window, e, deliver, take;
    logic found;
    logic [2:0] st;
    logic [12:0] p;
    avail = int'(13'(cm_ptr - rd_ptr));
    st = ST_OK;
    found = 1'b0;
    e = 0;
    if (avail == 0) begin
      push(KIND_END, 8'h00, ST_NOLINE, 7'd0, 1'b1);
      return;
    end
    window = (avail < int'(lim) + 1) ? avail : int'(lim) + 1;
    for (int i = 0; i < window; i++) begin
      p = rd_ptr + 13'(i);
      if (!found && flag_q[p[AW-1:0]]) begin
        found = 1'b1;
        e = i;
      end
    end
    p = rd_ptr + 13'(e);
    if (found && store_q[p[AW-1:0]] == 8'h00) begin
      deliver = e;
      take = e + 1;
      flag_q[p[AW-1:0]] = 1'b0;
      st = ST_EOF;
    end else begin
      deliver = found ? e + 1 : window;
      if (deliver > int'(lim)) deliver = int'(lim);
      take = deliver;
      if (found && e < deliver) flag_q[p[AW-1:0]] = 1'b0;
    end
    for (int i = 0; i < deliver; i++) begin
      p = rd_ptr + 13'(i);
      push(KIND_DATA, store_q[p[AW-1:0]], st, 7'd0, 1'b0);
    end
    rd_ptr = rd_ptr + 13'(take);
    push(KIND_END, 8'h00, st, 7'(take), 1'b1);
  endfunction

  function void note_item(logic cmd, logic [7:0] b, logic [5:0] lim);
    if (cmd == CMD_RX) receive_byte(b);
    else read_line(lim);
  endfunction

  function void check_result(editor_result_t got);
    editor_result_t exp_r;
    results_seen++;
    if (pending.size() == 0) begin
      $error("unexpected result: kind %0d byte %h", got.kind, got.data);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    if (got.kind != exp_r.kind) begin
      $error("kind: expected %0d, got %0d", exp_r.kind, got.kind);
      errors++;
    end
    if (got.data != exp_r.data) begin
      $error("out_byte: expected %h, got %h", exp_r.data, got.data);
      errors++;
    end
    if (got.status != exp_r.status) begin
      $error("status: expected %0d, got %0d", exp_r.status, got.status);
      errors++;
    end
    if (got.consumed != exp_r.consumed) begin
      $error("consumed: expected %0d, got %0d", exp_r.consumed, got.consumed);
      errors++;
    end
    if (got.last != exp_r.last) begin
      $error("last: expected %0d, got %0d", exp_r.last, got.last);
      errors++;
    end
  endfunction
endclass

module tb_canonical_line_editor;
  localparam int CYCLE_LIMIT = 3000000;

  logic       clk_i, rst_ni, start, busy;
  logic       command_i;
  logic [7:0] rx_byte_i;
  logic [5:0] read_limit_i;
  logic       cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;
  logic       result_valid_o;
  logic [1:0] kind_o;
  logic [7:0] out_byte_o;
  logic [2:0] status_o;
  logic [6:0] consumed_o;
  logic       last_o;

  line_editor_scoreboard sb;
  logic [7:0] cfg_now [4];
  int cycles, items, reads, burst_left;

  canonical_line_editor dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Every strobed result is checked at the edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.check_result('{kind_o, out_byte_o, status_o, consumed_o, last_o});
    end
  end

  // Sender gaps come between bursts of random length.
  task automatic sender_gap();
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 6);
    end else begin
      burst_left--;
    end
  endtask

  // One transaction: hold start until the block takes it.
  task automatic send(logic cmd, logic [7:0] b, logic [5:0] lim, logic idle_ok = 1'b1);
    command_i = cmd;
    rx_byte_i = b;
    read_limit_i = lim;
    start = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_item(cmd, b, lim);
    items++;
    if (cmd == CMD_READ) reads++;
    @(negedge clk_i);
    start = 1'b0;
    if (idle_ok) sender_gap();
  endtask

  task automatic rx(logic [7:0] b);
    send(CMD_RX, b, 6'($urandom_range(0, 63)));
  endtask

  task automatic rd(logic [5:0] lim);
    send(CMD_READ, 8'($urandom_range(0, 255)), lim);
  endtask

  // Wait until every expected result has come and the block has settled.
  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_regs(logic [7:0] nl, logic [7:0] er, logic [7:0] it, logic [7:0] ef);
    logic [7:0] vals [4];
    vals = '{nl, er, it, ef};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i = 1'b1;
      cfg_index_i = 2'(i);
      cfg_data_i = vals[i];
      sb.set_reg(2'(i), vals[i]);
      cfg_now[i] = vals[i];
      @(negedge clk_i);
    end
    cfg_we_i = 1'b0;
  endtask

  // A well-formed line with random content, then up to two reads.
  task automatic random_line();
    int len, r;
    len = $urandom_range(0, 10);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 65) rx(8'($urandom_range(32, 126)));
      else if (r < 75) rx(8'($urandom_range(0, 31)));
      else if (r < 85) rx(8'($urandom_range(128, 255)));
      else rx(cfg_now[REG_ERASE]);
    end
    r = $urandom_range(0, 99);
    if (r < 70) rx(cfg_now[REG_NEWLINE]);
    else if (r < 85) rx(cfg_now[REG_EOF]);
    else rx(cfg_now[REG_INTR]);
    repeat ($urandom_range(0, 2)) begin
      rd($urandom_range(0, 2) == 0 ? 6'($urandom_range(1, 4)) : 6'($urandom_range(1, 63)));
    end
  endtask

  task automatic random_phase(int count);
    int target;
    target = items + count;
    while (items < target) begin
      if ($urandom_range(0, 4) == 0) begin
        send(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
      end else begin
        random_line();
      end
    end
  endtask

  initial begin
    start = 1'b0;
    command_i = CMD_RX;
    rx_byte_i = '0;
    read_limit_i = 6'd1;
    cfg_we_i = 1'b0;
    cfg_index_i = REG_NEWLINE;
    cfg_data_i = '0;
    cycles = 0;
    items = 0;
    reads = 0;
    burst_left = 0;
    sb = new();
    rst_ni = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part at the reset settings.
    write_regs(8'd10, 8'd127, 8'd3, 8'd4);
    rx(8'h41); rx(8'hFF); rx(8'h80); rx(8'h00); rx(8'h1F); rx(8'h20); rx(8'h7E);
    rx(8'd127); rx(8'd127);           // two printable bytes erased
    rx(8'd10);
    rd(6'd0); rd(6'd63); rd(6'd63);   // zero limit, full read, then no line ready
    rx(8'h78); rx(8'd4); rd(6'd5);    // end-of-file read
    rx(8'd4); rd(6'd0);               // zero limit consumes a leading end-of-file mark
    rx(8'h61); rx(8'h62); rx(8'd3); rd(6'd63);
    rx(8'd127);                        // erase with nothing uncommitted
    rx(8'h71); rx(8'h72); rx(8'd10); rd(6'd1); rd(6'd1); rd(6'd63);
    drain();

    // Random phases over several register settings, extremes included.
    random_phase(80);
    drain();
    write_regs(8'hFF, 8'h00, 8'h80, 8'h7F);
    random_phase(80);
    drain();
    write_regs(8'h0D, 8'h08, 8'h1A, 8'h00);
    random_phase(80);
    drain();
    write_regs(8'h2A, 8'h2A, 8'h2A, 8'h2A);   // newline takes priority
    random_phase(80);
    drain();

    $display("Covered %0d transactions (%0d reads) and %0d results over four settings,",
             items, reads, sb.results_seen);
    $display("including erased control bytes, zero-limit reads and all terminator kinds.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
